/* src/rcfd_pkg.sv */
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types, constants and the tangent table of the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package rcfd_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int STORE_DEPTH = 15;
  localparam int POS_W       = 5;
  localparam int CH_W        = 11;
  localparam logic [CH_W-1:0] CENTER = 11'd1024;

  // configuration register indexes
  localparam logic [0:0] REG_DEADBAND   = 1'b0;
  localparam logic [0:0] REG_FULL_SCALE = 1'b1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_SETUP,
    ST_ANGLE,
    ST_DIVIDE,
    ST_NEXT,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;      // latch a stick vector and start
    logic sel_right; // 0 left stick, 1 right stick
    logic ang_step;  // one tangent comparison
    logic div_step;  // one quotient bit
    logic save;      // store stick result
    logic show;      // raise output valid
  } cmd_t;

  typedef struct packed {
    logic ang_done;
    logic div_done;
  } status_t;

  // round(tan(k deg) * 2^16), k = 0..45
  function automatic logic [16:0] tan_q16(input logic [5:0] k);
    logic [16:0] t;
    unique case (k)
      6'd0: t = 17'd0;      6'd1: t = 17'd1144;   6'd2: t = 17'd2289;
      6'd3: t = 17'd3435;   6'd4: t = 17'd4583;   6'd5: t = 17'd5734;
      6'd6: t = 17'd6888;   6'd7: t = 17'd8047;   6'd8: t = 17'd9210;
      6'd9: t = 17'd10380;  6'd10: t = 17'd11556; 6'd11: t = 17'd12739;
      6'd12: t = 17'd13930; 6'd13: t = 17'd15130; 6'd14: t = 17'd16340;
      6'd15: t = 17'd17560; 6'd16: t = 17'd18792; 6'd17: t = 17'd20036;
      6'd18: t = 17'd21294; 6'd19: t = 17'd22566; 6'd20: t = 17'd23853;
      6'd21: t = 17'd25157; 6'd22: t = 17'd26478; 6'd23: t = 17'd27818;
      6'd24: t = 17'd29179; 6'd25: t = 17'd30560; 6'd26: t = 17'd31964;
      6'd27: t = 17'd33392; 6'd28: t = 17'd34846; 6'd29: t = 17'd36327;
      6'd30: t = 17'd37837; 6'd31: t = 17'd39378; 6'd32: t = 17'd40951;
      6'd33: t = 17'd42560; 6'd34: t = 17'd44205; 6'd35: t = 17'd45889;
      6'd36: t = 17'd47615; 6'd37: t = 17'd49385; 6'd38: t = 17'd51202;
      6'd39: t = 17'd53070; 6'd40: t = 17'd54991; 6'd41: t = 17'd56970;
      6'd42: t = 17'd59009; 6'd43: t = 17'd61113; 6'd44: t = 17'd63287;
      default: t = 17'd65536;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

/* src/rc_frame_decode_to_polar.sv */
// ----------------------------------------------------------------------------
// rc_frame_decode_to_polar
// Remote-control frame decoder with polar stick output.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while collecting. After the last byte of a
// frame the block stalls its input while a serial tangent-table search and a
// 17-step restoring divider, shared by both sticks, work on each stick in
// turn; the result then holds until taken.
`default_nettype none
module rc_frame_decode_to_polar
  import rcfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       left_push_pct,
  output logic [8:0]       left_angle_deg,
  output logic [7:0]       right_push_pct,
  output logic [8:0]       right_angle_deg,
  output logic [7:0]       switch_code,
  output logic [7:0]       key_bits,
  output logic signed [15:0] mouse_x,
  output logic signed [15:0] mouse_y,
  output logic signed [15:0] mouse_z,
  output logic [7:0]       press_left,
  output logic [7:0]       press_right
);

  cmd_t             cmd;
  status_t          status;
  logic             store_en;
  logic [POS_W-1:0] store_pos;

  rcfd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_start(frame_start), .out_stall, .status,
    .in_stall, .out_valid, .store_en, .store_pos, .cmd
  );

  rcfd_datapath u_dp (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_data, .store_en, .store_pos,
    .data_byte, .cmd, .status, .left_push_pct, .left_angle_deg,
    .right_push_pct, .right_angle_deg, .switch_code, .key_bits,
    .mouse_x, .mouse_y, .mouse_z, .press_left, .press_right
  );

endmodule
`default_nettype wire

/* src/rcfd_ctrl.sv */
// ----------------------------------------------------------------------------
// rcfd_ctrl
// Sequencer: byte position, frame completion and the per-stick work.
// ----------------------------------------------------------------------------
`default_nettype none
module rcfd_ctrl
  import rcfd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_start,
  input  wire logic    out_stall,
  input  wire status_t status,
  output logic         in_stall,
  output logic         out_valid,
  output logic         store_en,
  output logic [POS_W-1:0] store_pos,
  output cmd_t         cmd
);

  state_t state, state_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             right, right_next;
  logic             accept;
  logic [POS_W-1:0] eff_pos;
  logic             last;

  assign in_stall  = (state != ST_COLLECT);
  assign out_valid = (state == ST_HOLD);
  assign accept    = in_valid && !in_stall;
  assign eff_pos   = in_start ? '0 : pos;
  assign store_pos = eff_pos;
  assign store_en  = accept && (in_start || pos != '0);
  assign last      = (eff_pos == POS_W'(FRAME_BYTES - 1));

  // next state
  always_comb begin
    state_next = state;
    pos_next   = pos;
    right_next = right;
    unique case (state)
      ST_COLLECT: begin
        if (store_en) begin
          if (last) begin
            pos_next   = '0;
            right_next = 1'b0;
            state_next = ST_SETUP;
          end else begin
            pos_next = eff_pos + POS_W'(1);
          end
        end
      end
      ST_SETUP:  state_next = ST_ANGLE;
      ST_ANGLE:  if (status.ang_done) state_next = ST_DIVIDE;
      ST_DIVIDE: if (status.div_done) state_next = ST_NEXT;
      ST_NEXT: begin
        if (right) state_next = ST_HOLD;
        else begin
          right_next = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_HOLD:   if (!out_stall) state_next = ST_COLLECT;
      default:   state_next = ST_COLLECT;
    endcase
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.sel_right = right;
    unique case (state)
      ST_SETUP:  cmd.load     = 1'b1;
      ST_ANGLE:  cmd.ang_step = 1'b1;
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_NEXT:   cmd.save     = 1'b1;
      default:   cmd.show     = (state == ST_HOLD);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      pos   <= '0;
      right <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      right <= right_next;
    end
  end

endmodule
`default_nettype wire

/* src/rcfd_datapath.sv */
// ----------------------------------------------------------------------------
// rcfd_datapath
// Frame store, channel unpack, serial atan2 search and restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module rcfd_datapath
  import rcfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic        store_en,
  input  wire logic [POS_W-1:0] store_pos,
  input  wire logic [7:0]  data_byte,
  input  wire cmd_t        cmd,
  output status_t          status,
  output logic [7:0]       left_push_pct,
  output logic [8:0]       left_angle_deg,
  output logic [7:0]       right_push_pct,
  output logic [8:0]       right_angle_deg,
  output logic [7:0]       switch_code,
  output logic [7:0]       key_bits,
  output logic signed [15:0] mouse_x,
  output logic signed [15:0] mouse_y,
  output logic signed [15:0] mouse_z,
  output logic [7:0]       press_left,
  output logic [7:0]       press_right
);

  logic [7:0]  deadband;
  logic [10:0] full_scale;
  logic [7:0]  fb [STORE_DEPTH];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband   <= 8'd10;
      full_scale <= 11'd660;
    end else if (cfg_we && cfg_addr[1] == 1'b0) begin
      if (cfg_addr[0] == REG_DEADBAND) deadband <= cfg_data[7:0];
      else                              full_scale <= cfg_data;
    end
  end

  // frame bytes; trailing bytes are not stored
  always_ff @(posedge clk) begin
    if (store_en && store_pos < POS_W'(STORE_DEPTH))
      fb[store_pos[3:0]] <= data_byte;
  end

  // unpack channels
  logic [CH_W-1:0] ch0, ch1, ch2, ch3;
  assign ch0 = {fb[1][2:0], fb[0]};
  assign ch1 = {fb[2][5:0], fb[1][7:3]};
  assign ch2 = {fb[4][0], fb[3], fb[2][7:6]};
  assign ch3 = {fb[5][3:0], fb[4][7:1]};

  function automatic logic signed [11:0] snap_off(input logic [CH_W-1:0] c,
                                                 input logic [7:0] db);
    logic signed [12:0] d;
    logic [11:0] a;
    d = $signed({2'b00, c}) - 13'sd1024;
    a = d[12] ? 12'(-d) : d[11:0];
    if (a < {4'd0, db}) return 12'sd0;
    return d[11:0];
  endfunction

  // stick selection
  logic signed [11:0] dx, dy;
  always_comb begin
    if (cmd.sel_right) begin
      dx = snap_off(ch0, deadband);
      dy = snap_off(ch1, deadband);
    end else begin
      dx = snap_off(ch2, deadband);
      dy = snap_off(ch3, deadband);
    end
  end

  // quadrant fold
  logic [1:0]  q_in;
  logic [10:0] u_in, v_in;
  always_comb begin
    priority if (dx > 0 && dy >= 0) begin
      q_in = 2'd0; u_in = 11'(dx);  v_in = 11'(dy);
    end else if (dx <= 0 && dy > 0) begin
      q_in = 2'd1; u_in = 11'(dy);  v_in = 11'(-dx);
    end else if (dx < 0 && dy <= 0) begin
      q_in = 2'd2; u_in = 11'(-dx); v_in = 11'(-dy);
    end else begin
      q_in = 2'd3; u_in = 11'(-dy); v_in = 11'(dx);
    end
  end

  logic [10:0] ax, ay, mx;
  assign ax = dx[11] ? 11'(-dx) : 11'(dx);
  assign ay = dy[11] ? 11'(-dy) : 11'(dy);
  assign mx = (ax > ay) ? ax : ay;

  // angle search, one table entry per cycle
  logic [1:0]  q;
  logic [10:0] u, v;
  logic        zero_vec, low_half;
  logic [5:0]  k;
  logic [6:0]  best;
  logic        found;
  logic [27:0] lhs, rhs;

  assign lhs = low_half ? {v, 17'd0} >> 1 : {u, 17'd0} >> 1;
  assign rhs = low_half ? tan_q16(k) * u : tan_q16(k) * v;

  // restoring divider of 100*m by full_scale, or by 1 when full_scale is zero
  logic [16:0] dividend;
  logic [11:0] rem;
  logic [16:0] quo;
  logic [4:0]  dbit;
  logic [10:0] fs;
  logic [12:0] trial;
  assign fs    = (full_scale == '0) ? 11'd1 : full_scale;
  assign trial = {rem, dividend[16]} - {2'b00, fs};

  assign status.ang_done = zero_vec || found || (low_half && k == 6'd44)
                           || (!low_half && k == 6'd45);
  assign status.div_done = (dbit == 5'd17);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      k     <= '0;
      dbit  <= '0;
    end else if (cmd.load) begin
      q        <= q_in;
      u        <= u_in;
      v        <= v_in;
      zero_vec <= (dx == 0) && (dy == 0);
      low_half <= v_in < u_in;
      k        <= 6'd1;
      best     <= (v_in < u_in) ? 7'd0 : 7'd45;
      found    <= 1'b0;
      dividend <= 17'(mx) * 17'd100;
      rem      <= '0;
      quo      <= '0;
      dbit     <= '0;
    end else if (cmd.ang_step && !status.ang_done) begin
      // low half keeps the last k passing; high half stops at first hit
      if (low_half) begin
        if (lhs >= rhs) best <= {1'b0, k};
      end else if (lhs <= rhs) begin
        best  <= 7'(7'd90 - {1'b0, k});
        found <= 1'b1;
      end
      k <= k + 6'd1;
    end else if (cmd.ang_step && low_half && !zero_vec && !found) begin
      if (lhs >= rhs) best <= {1'b0, k};
      found <= 1'b1;
    end else if (cmd.ang_step && !low_half && !zero_vec && !found) begin
      if (lhs <= rhs) best <= 7'(7'd90 - {1'b0, k});
      found <= 1'b1;
    end else if (cmd.div_step && dbit != 5'd17) begin
      if (!trial[12]) begin
        rem <= trial[11:0];
        quo <= {quo[15:0], 1'b1};
      end else begin
        rem <= {rem[10:0], dividend[16]};
        quo <= {quo[15:0], 1'b0};
      end
      dividend <= {dividend[15:0], 1'b0};
      dbit     <= dbit + 5'd1;
    end
  end

  // final angle and push
  logic [9:0] ang_sum;
  logic [8:0] ang;
  logic [7:0] push;
  assign ang_sum = 10'd90 * {8'd0, q} + {3'd0, best} + 10'd270;
  assign ang  = zero_vec ? 9'd270
              : (ang_sum >= 10'd720) ? 9'(ang_sum - 10'd720)
              : (ang_sum >= 10'd360) ? 9'(ang_sum - 10'd360) : ang_sum[8:0];
  assign push = (quo > 17'd255) ? 8'd255 : quo[7:0];

  always_ff @(posedge clk) begin
    if (cmd.save) begin
      if (cmd.sel_right) begin
        right_push_pct  <= push;
        right_angle_deg <= ang;
      end else begin
        left_push_pct  <= push;
        left_angle_deg <= ang;
      end
    end
  end

  // plain fields
  assign switch_code = (8'h10 << fb[5][7:6]) | (8'h01 << fb[5][5:4]);
  assign key_bits    = fb[14];
  assign mouse_x     = {fb[7], fb[6]};
  assign mouse_y     = {fb[9], fb[8]};
  assign mouse_z     = {fb[11], fb[10]};
  assign press_left  = fb[12];
  assign press_right = fb[13];

endmodule
`default_nettype wire

/* src/rcfd_checker.sv */
// ----------------------------------------------------------------------------
// rcfd_checker
// Port-level checks of the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none
module rcfd_port_checks (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [8:0] left_angle_deg,
  input wire logic [8:0] right_angle_deg
);

  // no input transfer while a result is offered
  a_stall_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result held");

  // a held result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

  // angles stay in range
  a_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_angle_deg < 9'd360 && right_angle_deg < 9'd360))
    else $error("angle out of range");

  // a held left angle does not change
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(left_angle_deg))
    else $error("result changed while stalled");

endmodule

bind rc_frame_decode_to_polar rcfd_port_checks u_chk (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .left_angle_deg,
  .right_angle_deg
);
`default_nettype wire

/* sim/rcfd_checker.sv */
// ----------------------------------------------------------------------------
// rcfd_checker
// Watches the byte and result channels of the frame decoder, predicts each
// decoded frame from the transferred bytes and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module rcfd_checker
  import rcfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_start,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  left_push_pct,
  input  wire logic [8:0]  left_angle_deg,
  input  wire logic [7:0]  right_push_pct,
  input  wire logic [8:0]  right_angle_deg,
  input  wire logic [7:0]  switch_code,
  input  wire logic [7:0]  key_bits,
  input  wire logic signed [15:0] mouse_x,
  input  wire logic signed [15:0] mouse_y,
  input  wire logic signed [15:0] mouse_z,
  input  wire logic [7:0]  press_left,
  input  wire logic [7:0]  press_right,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  lpush;
    logic [8:0]  lang;
    logic [7:0]  rpush;
    logic [8:0]  rang;
    logic [7:0]  sw;
    logic [7:0]  keys;
    logic [15:0] mx;
    logic [15:0] my;
    logic [15:0] mz;
    logic [7:0]  pl;
    logic [7:0]  pr;
  } frame_res_t;

  frame_res_t       decoded_q[$];
  logic [POS_W-1:0] byte_pos;
  logic [7:0]       frame_bytes [STORE_DEPTH];
  logic [7:0]       deadband;
  logic [10:0]      full_scale;

  function automatic int snap_center(int c);
    if (c < 1024 + int'(deadband) && c > 1024 - int'(deadband)) return 1024;
    return c;
  endfunction

  // floor of angle within a quadrant, u > 0, v >= 0
  function automatic int deg_in_quadrant(longint u, longint v);
    int best;
    best = 0;
    if (v < u) begin
      for (int k = 1; k <= 44; k++)
        if ((v << 16) >= longint'(tan_q16(6'(k))) * u) best = k;
      return best;
    end
    for (int k = 1; k <= 45; k++)
      if ((u << 16) <= longint'(tan_q16(6'(k))) * v) return 90 - k;
    return 45;
  endfunction

  function automatic logic [8:0] stick_heading(int dx, int dy);
    int q, u, v;
    if (dx == 0 && dy == 0) return 9'd270;
    if (dx > 0 && dy >= 0) begin q = 0; u = dx; v = dy; end
    else if (dx <= 0 && dy > 0) begin q = 1; u = dy; v = -dx; end
    else if (dx < 0 && dy <= 0) begin q = 2; u = -dx; v = -dy; end
    else begin q = 3; u = -dy; v = dx; end
    return 9'((90 * q + deg_in_quadrant(u, v) + 270) % 360);
  endfunction

  function automatic logic [7:0] stick_push(int dx, int dy);
    int ax, ay, m, fs, p;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    m  = ax > ay ? ax : ay;
    fs = full_scale == 0 ? 1 : int'(full_scale);
    p  = (100 * m) / fs;
    return p > 255 ? 8'd255 : 8'(p);
  endfunction

  function automatic frame_res_t decode_frame();
    frame_res_t r;
    int ch0, ch1, ch2, ch3, lx, ly, rx, ry;
    logic [1:0] s1, s2;
    ch0 = int'({frame_bytes[1][2:0], frame_bytes[0]});
    ch1 = int'({frame_bytes[2][5:0], frame_bytes[1][7:3]});
    ch2 = int'({frame_bytes[4][0], frame_bytes[3], frame_bytes[2][7:6]});
    ch3 = int'({frame_bytes[5][3:0], frame_bytes[4][7:1]});
    s1 = frame_bytes[5][7:6];
    s2 = frame_bytes[5][5:4];
    lx = snap_center(ch2) - 1024;
    ly = snap_center(ch3) - 1024;
    rx = snap_center(ch0) - 1024;
    ry = snap_center(ch1) - 1024;
    r.lpush = stick_push(lx, ly);
    r.lang  = stick_heading(lx, ly);
    r.rpush = stick_push(rx, ry);
    r.rang  = stick_heading(rx, ry);
    r.sw    = (8'h10 << s1) | (8'h01 << s2);
    r.keys  = frame_bytes[14];
    r.mx    = {frame_bytes[7], frame_bytes[6]};
    r.my    = {frame_bytes[9], frame_bytes[8]};
    r.mz    = {frame_bytes[11], frame_bytes[10]};
    r.pl    = frame_bytes[12];
    r.pr    = frame_bytes[13];
    return r;
  endfunction

  // track register writes and byte transfers, compare result transfers
  always @(posedge clk) begin
    int pos;
    frame_res_t got, want;
    if (rst) begin
      byte_pos   <= '0;
      deadband   <= 8'd10;
      full_scale <= 11'd660;
      decoded_q.delete();
      fail_count <= 0;
      pending    <= 0;
      for (int i = 0; i < STORE_DEPTH; i++) frame_bytes[i] = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_IDX_W'(REG_DEADBAND)) deadband <= cfg_data[7:0];
        else if (cfg_addr == CFG_IDX_W'(REG_FULL_SCALE)) full_scale <= cfg_data;
      end
      if (in_valid && !in_stall && (frame_start || byte_pos != 0)) begin
        pos = frame_start ? 0 : int'(byte_pos);
        if (pos < STORE_DEPTH) frame_bytes[pos] = data_byte;
        pos++;
        if (pos >= FRAME_BYTES) begin
          byte_pos <= '0;
          decoded_q.push_back(decode_frame());
        end else begin
          byte_pos <= POS_W'(pos);
        end
      end
      if (out_valid && !out_stall) begin
        got = '{left_push_pct, left_angle_deg, right_push_pct, right_angle_deg,
                switch_code, key_bits, mouse_x, mouse_y, mouse_z,
                press_left, press_right};
        if (decoded_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result transfer: %h", got);
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("result mismatch: expected %h got %h", want, got);
          end
        end
      end
      pending <= decoded_q.size();
    end
  end

endmodule
`default_nettype wire

/* sim/tb_rc_frame_decode_to_polar.sv */
// ----------------------------------------------------------------------------
// tb_rc_frame_decode_to_polar
// Drives remote-control frames, noise and register settings into the decoder
// with random idling on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_rc_frame_decode_to_polar;
  import rcfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int TARGET_BYTES = 1400;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = '0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] left_push_pct, right_push_pct, switch_code, key_bits;
  logic [7:0] press_left, press_right;
  logic [8:0] left_angle_deg, right_angle_deg;
  logic signed [15:0] mouse_x, mouse_y, mouse_z;
  int  fail_count, pending;
  bit  hold_req = 1'b0;
  bit  calm = 1'b0;
  int  bytes_sent = 0;
  logic [7:0] fb [FRAME_BYTES];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rc_frame_decode_to_polar uut (.*);
  rcfd_checker chk (.*);

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one byte from a falling edge, hold until transferred
  task automatic send_byte(input logic [7:0] b, input logic s);
    int g;
    in_valid = 1'b1;
    data_byte = b;
    frame_start = s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
    g = idle_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] a, input int v);
    cfg_we = 1'b1;
    cfg_addr = a;
    cfg_data = CFG_DATA_W'(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // wait until every decoded frame is out and the block has settled
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [10:0] pick_channel(int db);
    case ($urandom_range(0, 5))
      0: return 11'd1024;
      1, 2: return 11'(1024 + $urandom_range(0, 2 * db + 4) - db - 2);
      3: case ($urandom_range(0, 3))
           0: return 11'd0;
           1: return 11'd2047;
           2: return 11'd364;
           default: return 11'd1684;
         endcase
      default: return 11'($urandom);
    endcase
  endfunction

  // build a frame with the given channels and switches, random remainder
  task automatic build_frame(input logic [10:0] c0, c1, c2, c3,
                             input logic [1:0] s1, s2);
    logic [43:0] bits;
    bits = {c3, c2, c1, c0};
    for (int i = 0; i < FRAME_BYTES; i++) fb[i] = 8'($urandom);
    for (int i = 0; i < 5; i++) fb[i] = bits[8*i +: 8];
    fb[5] = {s1, s2, bits[43:40]};
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_byte(fb[i], i == 0);
  endtask

  task automatic random_frames(input int nbytes, input int db);
    int stop;
    stop = bytes_sent + nbytes;
    while (bytes_sent < stop) begin
      build_frame(pick_channel(db), pick_channel(db), pick_channel(db),
                  pick_channel(db), 2'($urandom), 2'($urandom));
      case ($urandom_range(0, 9))
        0: send_frame($urandom_range(1, FRAME_BYTES - 1));   // cut short
        1: begin                                          // stray bytes
          send_frame(FRAME_BYTES);
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
        end
        default: send_frame(FRAME_BYTES);
      endcase
    end
  endtask

  // receiver side: random stalls, one long hold-off on request
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (600) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
      end else begin
        g = idle_len();
        if (g > 0) begin
          out_stall = 1'b1;
          repeat (g) @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("** rc_frame_decode_to_polar: FAILED **");
    $finish;
  end

  initial begin
    int db_set [7] = '{10, 0, 255, 37, 200, 3, 128};
    int fs_set [7] = '{660, 1, 1024, 0, 2047, 100, 513};
    int wait_cycles;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed: stray byte, restart mid-frame, extreme channels and switches
    send_byte(8'hFF, 1'b0);
    build_frame(11'd0, 11'd2047, 11'd1024, 11'd1014, 2'd3, 2'd0);
    send_frame(4);
    fb[6] = 8'h00; fb[7] = 8'h80; fb[8] = 8'hFF; fb[9] = 8'h7F;
    send_frame(FRAME_BYTES);
    send_byte(8'h00, 1'b0);
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_IDX_W'(REG_DEADBAND), db_set[ph]);
      write_reg(CFG_IDX_W'(REG_FULL_SCALE), fs_set[ph]);
      if (ph == 2) write_reg(REG_UNUSED, 0);
      calm = (ph == 4);
      if (ph == 3) hold_req = 1'b1;
      random_frames(TARGET_BYTES / 7, db_set[ph]);
      settle();
    end

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("** rc_frame_decode_to_polar: PASSED **");
    else
      $display("** rc_frame_decode_to_polar: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
